/* rtl/imaenc_pkg.sv */
// ----------------------------------------------------------------------------
// imaenc_pkg
// Shared constants, tables and types of the IMA ADPCM block encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imaenc_pkg;

  localparam int unsigned SamplesPerBlock = 505;
  localparam int unsigned PosW            = 13;
  localparam int unsigned IdxW            = 7;
  localparam int unsigned StepW           = 15;
  localparam int unsigned GrpMax          = 4;
  localparam int unsigned CntW            = 3;

  localparam logic [PosW-1:0] LastPos  = PosW'(SamplesPerBlock - 1);
  localparam logic [IdxW-1:0] MaxIndex = IdxW'(88);

  localparam logic [StepW-1:0] StepTab [89] = '{
    15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
    15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41,
    15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97,
    15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209,
    15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408, 15'd449,
    15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876, 15'd963,
    15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707, 15'd1878,
    15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327, 15'd3660,
    15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484, 15'd7132,
    15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
    15'd27086, 15'd29794, 15'd32767
  };

  function automatic logic [StepW-1:0] step_lookup(input logic [IdxW-1:0] idx);
    logic [StepW-1:0] step;
    if (idx > MaxIndex) begin
      step = StepTab[88];
    end else begin
      step = StepTab[idx];
    end
    return step;
  endfunction

  // signed index adjustment for the three magnitude bits of a code
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

  typedef struct packed {
    logic [CntW-1:0]       cnt;
    logic [GrpMax-1:0][7:0] bytes;
    logic [GrpMax-1:0]     ends;
  } imaenc_grp_t;

endpackage

`default_nettype wire

/* rtl/imaenc_if.sv */
// ----------------------------------------------------------------------------
// imaenc_if
// Valid/ready channels of the encoder: PCM samples in, encoded bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface imaenc_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface imaenc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       block_end;

  modport source (output valid, output out_byte, output block_end, input ready);
  modport sink (input valid, input out_byte, input block_end, output ready);
endinterface

`default_nettype wire

/* rtl/ima_adpcm_block_encoder_core.sv */
// ----------------------------------------------------------------------------
// ima_adpcm_block_encoder_core
// IMA ADPCM 4-bit block encoder: PCM samples in, block bytes out.
//
//   channel  dir  payload                 transaction
//   in_i     in   sample[15:0] signed     valid && ready
//   out_o    out  out_byte[7:0],block_end valid && ready
//
// A sample is registered, coded combinationally and its bytes loaded into
// the result register; bytes leave one per cycle while out_o is ready. A
// block-start sample gives four header bytes; a coded sample gives at most
// one byte and a new sample can enter every cycle while the result register
// is free. Stalls hold the result register and back up into the input register.
// Reset is asynchronous and clears the coder state to the start of a block.
// ----------------------------------------------------------------------------
`default_nettype none

module ima_adpcm_block_encoder_core
  import imaenc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  imaenc_sample_if.sink  in_i,
  imaenc_byte_if.source  out_o
);

  imaenc_grp_t grp;
  logic        load;
  logic        q_free;

  imaenc_coder u_coder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_free_i (q_free),
    .grp_o    (grp),
    .load_o   (load)
  );

  imaenc_byte_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .grp_i  (grp),
    .load_i (load),
    .free_o (q_free),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

/* rtl/imaenc_coder.sv */
// ----------------------------------------------------------------------------
// imaenc_coder
// Input register, encoder state and single-pass IMA code computation; builds
// the byte group that one sample produces.
// ----------------------------------------------------------------------------
`default_nettype none

module imaenc_coder
  import imaenc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  imaenc_sample_if.sink    in_i,
  input  wire logic        q_free_i,
  output imaenc_grp_t      grp_o,
  output logic             load_o
);

  logic               in_vld_q;
  logic signed [15:0] sample_q;
  logic signed [15:0] pred_q, pred_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [3:0]         held_q, held_d;
  logic               fire;

  logic [IdxW-1:0]    si;
  logic [StepW-1:0]   step;
  logic [16:0]        diff, mag, r1, r2, s_full, s_half, s_quar, delta;
  logic               neg, b2, b1, b0;
  logic [3:0]         code;
  logic signed [17:0] np;
  logic signed [7:0]  ni;
  logic               is_last;
  imaenc_grp_t        grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      sample_q <= in_i.sample;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q <= '0;
      idx_q  <= '0;
      pos_q  <= '0;
      held_q <= '0;
    end else if (fire) begin
      pred_q <= pred_d;
      idx_q  <= idx_d;
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

  always_comb begin
    si     = (idx_q > MaxIndex) ? MaxIndex : idx_q;
    step   = step_lookup(si);
    s_full = {2'b00, step};
    s_half = {3'b000, step[StepW-1:1]};
    s_quar = {4'b0000, step[StepW-1:2]};
    diff   = {sample_q[15], sample_q} - {pred_q[15], pred_q};
    neg    = diff[16];
    mag    = neg ? (17'd0 - diff) : diff;
    b2     = (mag >= s_full);
    r1     = b2 ? (mag - s_full) : mag;
    b1     = (r1 >= s_half);
    r2     = b1 ? (r1 - s_half) : r1;
    b0     = (r2 >= s_quar);
    delta  = {5'b00000, step[StepW-1:3]} + (b2 ? s_full : 17'd0)
           + (b1 ? s_half : 17'd0) + (b0 ? s_quar : 17'd0);
    code   = {neg, b2, b1, b0};
    np     = neg ? ({{2{pred_q[15]}}, pred_q} - $signed({1'b0, delta}))
                 : ({{2{pred_q[15]}}, pred_q} + $signed({1'b0, delta}));
    ni     = $signed({1'b0, si}) + 8'(index_adjust(code[2:0]));
  end

  always_comb begin
    pred_d     = pred_q;
    idx_d      = idx_q;
    held_d     = held_q;
    pos_d      = pos_q;
    grp        = '0;
    is_last    = (pos_q >= LastPos);
    if (pos_q == '0) begin
      pred_d       = sample_q;
      idx_d        = '0;
      held_d       = '0;
      pos_d        = PosW'(1);
      grp.cnt      = CntW'(GrpMax);
      grp.bytes[0] = sample_q[7:0];
      grp.bytes[1] = sample_q[15:8];
    end else begin
      if (np < -18'sd32768) begin
        pred_d = 16'sh8000;
      end else if (np > 18'sd32767) begin
        pred_d = 16'sh7fff;
      end else begin
        pred_d = np[15:0];
      end
      if (ni < 8'sd0) begin
        idx_d = '0;
      end else if (ni > $signed({1'b0, MaxIndex})) begin
        idx_d = MaxIndex;
      end else begin
        idx_d = ni[IdxW-1:0];
      end
      pos_d = is_last ? '0 : (pos_q + PosW'(1));
      if (pos_q[0]) begin
        held_d = code;
        if (is_last) begin
          grp.cnt      = CntW'(1);
          grp.bytes[0] = {4'b0000, code};
          grp.ends[0]  = 1'b1;
        end
      end else begin
        grp.cnt      = CntW'(1);
        grp.bytes[0] = {code, held_q};
        grp.ends[0]  = is_last;
      end
    end
  end

  assign fire     = in_vld_q && (q_free_i || (grp.cnt == '0));
  assign load_o   = fire && (grp.cnt != '0);
  assign grp_o    = grp;
  assign in_i.ready = !in_vld_q || fire;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MaxIndex)
    else $error("step index out of range");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("block position out of range");

  a_header_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (pos_q == '0) |=> (idx_q == '0) && (pos_q == PosW'(1)))
    else $error("block start did not reload state");

endmodule

`default_nettype wire

/* rtl/imaenc_byte_queue.sv */
// ----------------------------------------------------------------------------
// imaenc_byte_queue
// Result register holding one sample's byte group; shifts bytes out one per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module imaenc_byte_queue
  import imaenc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire imaenc_grp_t grp_i,
  input  wire logic        load_i,
  output logic             free_o,
  imaenc_byte_if.source    out_o
);

  logic [CntW-1:0]        cnt_q;
  logic [GrpMax-1:0][7:0] byte_q;
  logic [GrpMax-1:0]      end_q;
  logic                   pop;

  assign pop    = (cnt_q != '0) && out_o.ready;
  assign free_o = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= grp_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= grp_i.bytes;
      end_q  <= grp_i.ends;
    end else if (pop) begin
      byte_q <= {8'h00, byte_q[GrpMax-1:1]};
      end_q  <= {1'b0, end_q[GrpMax-1:1]};
    end
  end

  assign out_o.valid     = (cnt_q != '0);
  assign out_o.out_byte  = byte_q[0];
  assign out_o.block_end = end_q[0];

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded over pending bytes");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(GrpMax))
    else $error("byte count out of range");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> out_o.valid)
    else $error("loaded group not presented");

endmodule

`default_nettype wire
